// ----- hdl/pvt_pkg.sv -----
// ============================================================================
// pvt_pkg
// Shared types and constants for the polygon vertex table block.
// ============================================================================
package pvt_pkg;

  localparam int MaxVertices = 64;
  localparam int CoordBits   = 24;
  localparam int IdxBits     = $clog2(MaxVertices);
  localparam int CntBits     = $clog2(MaxVertices + 1);
  localparam int ThrBits     = 49;
  localparam int DistBits    = 64;
  localparam int DiffBits    = CoordBits + 1;
  localparam int ProdBits    = 2 * DiffBits + 1;
  localparam int WideBits    = ProdBits + 1;

  localparam logic [ThrBits-1:0] ThrReset = ThrBits'(66);

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_MOVE   = 2'd2,
    OP_INSIDE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_NO_HIT  = 2'd2,
    ST_UNUSED  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_NEAR_RD, S_NEAR_CMP, S_SHIFT_RD, S_SHIFT_WR,
    S_IN_V0, S_IN_ISSUE, S_IN_LOAD, S_IN_MUL, S_IN_SUB, S_IN_CMP, S_OUT
  } state_t;

endpackage

// ----- hdl/pvt_stream_if.sv -----
// ============================================================================
// pvt_stream_if
// Valid/ready channel carrying one payload.
// ============================================================================
interface pvt_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/polygon_vertex_table_with_inside_test.sv -----
// ============================================================================
// polygon_vertex_table_with_inside_test
// Ordered polygon table with nearest-vertex edits and crossing-number test.
// ============================================================================
// Channel | Dir | Payload
// in_*    | in  | opcode, point_x, point_y
// out_*   | out | status, inside_res, hit_index, vertex_count
// cfg_*   | in  | snap_threshold write data
// Add writes the new vertex at the end of the table. Remove and move scan
// every vertex for the nearest one; remove then shifts the later vertices
// down. The inside test visits every edge with one memory read per vertex
// visit, the staged edge multiply and a compare.
// Synchronous active-low reset clears the count and loads ThrReset into the threshold; the vertex
// memory is undefined until written.
// An item is taken only when the result register is empty.
module polygon_vertex_table_with_inside_test (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_opcode,
  input  logic signed [pvt_pkg::CoordBits-1:0] in_point_x,
  input  logic signed [pvt_pkg::CoordBits-1:0] in_point_y,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_status,
  output logic                     out_inside_res,
  output logic [pvt_pkg::IdxBits-1:0] out_hit_index,
  output logic [pvt_pkg::CntBits-1:0] out_vertex_count,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [pvt_pkg::ThrBits-1:0] cfg_data
);
  import pvt_pkg::*;

  // vertex memory, x and y side by side
  logic [2*CoordBits-1:0] mem [MaxVertices];
  logic [2*CoordBits-1:0] rd_r;
  logic [IdxBits-1:0]     ra, wa;
  logic                   we;
  logic [2*CoordBits-1:0] wd;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[ra];
  end

  state_t                state_r, state_nxt;
  logic [ThrBits-1:0]    thr_r;
  logic [CntBits-1:0]    total_r, total_nxt;
  opcode_t               op_r, op_nxt;
  coord_t                qx_r, qx_nxt, qy_r, qy_nxt;
  logic [CntBits-1:0]    k_r, k_nxt;
  logic                  found_r, found_nxt;
  logic [IdxBits-1:0]    best_r, best_nxt;
  logic [DistBits-1:0]   bestd_r, bestd_nxt;
  logic                  par_r, par_nxt;
  coord_t                p1x_r, p1x_nxt, p1y_r, p1y_nxt, v0x_r, v0x_nxt, v0y_r, v0y_nxt;
  coord_t                p2x_r, p2x_nxt, p2y_r, p2y_nxt;
  logic signed [ProdBits-1:0] m_r [6];
  logic signed [ProdBits-1:0] m_nxt [6];
  logic signed [WideBits-1:0] den_r, ns_r, nu_r, den_nxt, ns_nxt, nu_nxt;
  logic                  ov_r, ov_nxt;
  logic [1:0]            st_r, st_nxt;
  logic                  ins_r, ins_nxt;
  logic [IdxBits-1:0]    hit_r, hit_nxt;

  assign cfg_ready        = 1'b1;
  assign in_ready         = (state_r == S_IDLE) && !ov_r;
  assign out_valid        = ov_r;
  assign out_status       = st_r;
  assign out_inside_res   = ins_r;
  assign out_hit_index    = hit_r;
  assign out_vertex_count = total_r;

  // squared distance from point to read vertex
  logic signed [DiffBits-1:0] ddx, ddy;
  logic [DiffBits-1:0]        adx, ady;
  logic [DistBits-1:0]        sq_dist;
  always_comb begin
    ddx = DiffBits'(qx_r) - DiffBits'(coord_t'(rd_r[2*CoordBits-1:CoordBits]));
    ddy = DiffBits'(qy_r) - DiffBits'(coord_t'(rd_r[CoordBits-1:0]));
    adx = ddx[DiffBits-1] ? DiffBits'(-ddx) : DiffBits'(ddx);
    ady = ddy[DiffBits-1] ? DiffBits'(-ddy) : DiffBits'(ddy);
    sq_dist = DistBits'(adx) * DistBits'(adx) + DistBits'(ady) * DistBits'(ady);
  end

  // edge crossing compare on registered sums
  logic signed [WideBits-1:0] dn, sn, un;
  logic                       edge_hit;
  always_comb begin
    dn = den_r[WideBits-1] ? -den_r : den_r;
    sn = den_r[WideBits-1] ? -ns_r  : ns_r;
    un = den_r[WideBits-1] ? -nu_r  : nu_r;
    edge_hit = (den_r != '0) && !sn[WideBits-1] && (sn <= dn)
               && !un[WideBits-1] && (un <= dn);
  end

  // sequencer
  always_comb begin
    logic signed [DiffBits-1:0] edx, edy;
    logic [CntBits-1:0]         k1;
    logic                       better;
    state_nxt = state_r; total_nxt = total_r; op_nxt = op_r;
    qx_nxt = qx_r; qy_nxt = qy_r; k_nxt = k_r; found_nxt = found_r;
    best_nxt = best_r; bestd_nxt = bestd_r; par_nxt = par_r;
    p1x_nxt = p1x_r; p1y_nxt = p1y_r; p2x_nxt = p2x_r; p2y_nxt = p2y_r;
    v0x_nxt = v0x_r; v0y_nxt = v0y_r;
    m_nxt = m_r; den_nxt = den_r; ns_nxt = ns_r; nu_nxt = nu_r;
    ov_nxt = ov_r; st_nxt = st_r; ins_nxt = ins_r; hit_nxt = hit_r;
    ra = k_r[IdxBits-1:0]; wa = k_r[IdxBits-1:0]; we = 1'b0;
    wd = {qx_r, qy_r};
    k1 = k_r + CntBits'(1);
    edx = DiffBits'(p2x_r) - DiffBits'(p1x_r);
    edy = DiffBits'(p2y_r) - DiffBits'(p1y_r);
    better = !found_r || (sq_dist < bestd_r);
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          op_nxt = opcode_t'(in_opcode);
          qx_nxt = in_point_x; qy_nxt = in_point_y;
          k_nxt = '0; found_nxt = 1'b0; par_nxt = 1'b0;
          st_nxt = ST_DONE; ins_nxt = 1'b0; hit_nxt = '0;
          ra = '0;
          case (opcode_t'(in_opcode))
            OP_ADD: begin
              if (total_r >= CntBits'(MaxVertices)) st_nxt = ST_FULL;
              else begin
                we = 1'b1; wa = total_r[IdxBits-1:0];
                wd = {in_point_x, in_point_y};
                total_nxt = total_r + CntBits'(1);
              end
              state_nxt = S_OUT;
            end
            OP_INSIDE: state_nxt = (total_r == '0) ? S_OUT : S_IN_V0;
            default:   state_nxt = (total_r == '0) ? S_OUT : S_NEAR_RD;
          endcase
          if (total_r == '0 && opcode_t'(in_opcode) != OP_ADD
              && opcode_t'(in_opcode) != OP_INSIDE) st_nxt = ST_NO_HIT;
        end
      end
      S_NEAR_RD: state_nxt = S_NEAR_CMP;
      S_NEAR_CMP: begin
        if (better) begin
          found_nxt = 1'b1; best_nxt = k_r[IdxBits-1:0]; bestd_nxt = sq_dist;
        end
        k_nxt = k1;
        if (k1 < total_r) state_nxt = S_NEAR_RD;
        else if (!(better ? (sq_dist < DistBits'(thr_r))
                          : (bestd_r < DistBits'(thr_r)))) begin
          st_nxt = ST_NO_HIT; state_nxt = S_OUT;
        end else begin
          hit_nxt = better ? k_r[IdxBits-1:0] : best_r;
          if (op_r == OP_MOVE) begin
            we = 1'b1; wa = hit_nxt; state_nxt = S_OUT;
          end else begin
            k_nxt = {1'b0, hit_nxt};
            state_nxt = S_SHIFT_RD;
          end
        end
      end
      S_SHIFT_RD: begin
        if (k1 >= total_r) begin
          total_nxt = total_r - CntBits'(1);
          state_nxt = S_OUT;
        end else begin
          ra = k1[IdxBits-1:0];
          state_nxt = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        we = 1'b1; wd = rd_r; k_nxt = k1; state_nxt = S_SHIFT_RD;
      end
      // latch vertex 0 for the closing edge and as the first edge start
      S_IN_V0: begin
        v0x_nxt = coord_t'(rd_r[2*CoordBits-1:CoordBits]);
        v0y_nxt = coord_t'(rd_r[CoordBits-1:0]);
        p2x_nxt = v0x_nxt; p2y_nxt = v0y_nxt;
        state_nxt = S_IN_ISSUE;
      end
      // advance edge start; fetch vertex k+1 or close back to vertex 0
      S_IN_ISSUE: begin
        p1x_nxt = p2x_r; p1y_nxt = p2y_r;
        if (k1 < total_r) begin
          ra = k1[IdxBits-1:0];
          state_nxt = S_IN_LOAD;
        end else begin
          p2x_nxt = v0x_r; p2y_nxt = v0y_r;
          state_nxt = S_IN_MUL;
        end
      end
      S_IN_LOAD: begin
        p2x_nxt = coord_t'(rd_r[2*CoordBits-1:CoordBits]);
        p2y_nxt = coord_t'(rd_r[CoordBits-1:0]);
        state_nxt = S_IN_MUL;
      end
      S_IN_MUL: begin
        m_nxt[0] = ProdBits'(edx) * ProdBits'(qy_r);
        m_nxt[1] = ProdBits'(qx_r) * ProdBits'(edy);
        m_nxt[2] = ProdBits'(edx) * ProdBits'(p1y_r);
        m_nxt[3] = ProdBits'(p1x_r) * ProdBits'(edy);
        m_nxt[4] = ProdBits'(qx_r) * ProdBits'(p1y_r);
        m_nxt[5] = ProdBits'(qy_r) * ProdBits'(p1x_r);
        state_nxt = S_IN_SUB;
      end
      S_IN_SUB: begin
        den_nxt = WideBits'(m_r[0]) - WideBits'(m_r[1]);
        ns_nxt  = WideBits'(m_r[2]) - WideBits'(m_r[3]);
        nu_nxt  = WideBits'(m_r[4]) - WideBits'(m_r[5]);
        state_nxt = S_IN_CMP;
      end
      S_IN_CMP: begin
        par_nxt = par_r ^ edge_hit;
        k_nxt = k1;
        if (k1 < total_r) state_nxt = S_IN_ISSUE;
        else begin
          ins_nxt = par_r ^ edge_hit;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        ov_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; total_r <= '0; thr_r <= ThrReset; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; total_r <= total_nxt; ov_r <= ov_nxt;
      if (cfg_valid && cfg_ready) thr_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; qx_r <= qx_nxt; qy_r <= qy_nxt; k_r <= k_nxt;
    found_r <= found_nxt; best_r <= best_nxt; bestd_r <= bestd_nxt;
    par_r <= par_nxt; p1x_r <= p1x_nxt; p1y_r <= p1y_nxt;
    p2x_r <= p2x_nxt; p2y_r <= p2y_nxt; v0x_r <= v0x_nxt; v0y_r <= v0y_nxt;
    m_r <= m_nxt; den_r <= den_nxt; ns_r <= ns_nxt; nu_r <= nu_nxt;
    st_r <= st_nxt; ins_r <= ins_nxt; hit_r <= hit_nxt;
  end

endmodule

// ----- bench/tb.sv -----
// ============================================================================
// tb
// Self-checking bench for the polygon vertex table with inside test.
// Transactions enter through a queue-fed driver. The bench predicts each
// result from its own copy of the table and checks every result in order.
// The snap threshold is stepped through several values between phases.
// ============================================================================
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pvt_pkg::*;

  localparam longint ThrMax   = (64'd1 << ThrBits) - 1;
  localparam int     Grid     = 512;
  localparam int     CycLimit = 5000000;
  localparam int     Settle   = 5 * MaxVertices + 40;

  typedef struct packed {
    opcode_t op;
    coord_t  x;
    coord_t  y;
  } poly_cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               in_poly;
    logic [IdxBits-1:0] hit;
    logic [CntBits-1:0] count;
  } poly_resp_t;

  logic clk;
  logic rst_n;

  pvt_stream_if #(.payload_t(poly_cmd_t))         in_ch ();
  pvt_stream_if #(.payload_t(poly_resp_t))        out_ch ();
  pvt_stream_if #(.payload_t(logic [ThrBits-1:0])) cfg_ch ();

  polygon_vertex_table_with_inside_test DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_opcode        (in_ch.data.op),
    .in_point_x       (in_ch.data.x),
    .in_point_y       (in_ch.data.y),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_status       (out_ch.data.status),
    .out_inside_res   (out_ch.data.in_poly),
    .out_hit_index    (out_ch.data.hit),
    .out_vertex_count (out_ch.data.count),
    .cfg_valid        (cfg_ch.valid),
    .cfg_ready        (cfg_ch.ready),
    .cfg_data         (cfg_ch.data)
  );

  // Shadow polygon state
  coord_t            poly_x [MaxVertices];
  coord_t            poly_y [MaxVertices];
  int                poly_len;
  logic [ThrBits-1:0] snap_thr;

  poly_cmd_t  cmd_queue  [$];
  poly_resp_t resp_queue [$];
  int         errors;
  int         cyc;
  bit         in_taken;
  int         in_gap;
  int         out_hold;
  bit         idle_en;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Exact segment crossing test, origin to q against edge p1 -> p2
  function automatic bit edge_crosses(coord_t p1x, coord_t p1y, coord_t p2x,
                                      coord_t p2y, coord_t qx, coord_t qy);
    longint dx, dy, den, ns, nu;
    dx  = longint'(p2x) - longint'(p1x);
    dy  = longint'(p2y) - longint'(p1y);
    den = dx * qy - longint'(qx) * dy;
    ns  = dx * p1y - longint'(p1x) * dy;
    nu  = longint'(qx) * p1y - longint'(qy) * p1x;
    if (den == 0) return 1'b0;
    if (den < 0) begin
      den = -den;
      ns  = -ns;
      nu  = -nu;
    end
    return ns >= 0 && ns <= den && nu >= 0 && nu <= den;
  endfunction

  // First strictly nearest vertex within threshold, -1 if none
  function automatic int nearest_vertex(coord_t px, coord_t py);
    int                    best;
    longint unsigned       bestd, d;
    longint                ax, ay;
    best  = -1;
    bestd = 0;
    for (int k = 0; k < poly_len; k++) begin
      ax = longint'(px) - longint'(poly_x[k]);
      ay = longint'(py) - longint'(poly_y[k]);
      d  = ax * ax + ay * ay;
      if (best < 0 || d < bestd) begin
        best  = k;
        bestd = d;
      end
    end
    if (best >= 0 && bestd < snap_thr) return best;
    return -1;
  endfunction

  // Apply one command to the shadow table and return the expected response
  function automatic poly_resp_t apply_cmd(poly_cmd_t c);
    poly_resp_t r;
    int         id, n, crossings;
    r = '0;
    case (c.op)
      OP_ADD: begin
        if (poly_len >= MaxVertices) begin
          r.status = ST_FULL;
        end else begin
          poly_x[poly_len] = c.x;
          poly_y[poly_len] = c.y;
          poly_len++;
        end
      end
      OP_REMOVE, OP_MOVE: begin
        id = nearest_vertex(c.x, c.y);
        if (id < 0) begin
          r.status = ST_NO_HIT;
        end else begin
          r.hit = IdxBits'(id);
          if (c.op == OP_MOVE) begin
            poly_x[id] = c.x;
            poly_y[id] = c.y;
          end else begin
            for (int k = id; k + 1 < poly_len; k++) begin
              poly_x[k] = poly_x[k+1];
              poly_y[k] = poly_y[k+1];
            end
            poly_len--;
          end
        end
      end
      default: begin
        crossings = 0;
        for (int k = 0; k < poly_len; k++) begin
          n = (k + 1 < poly_len) ? k + 1 : 0;
          if (edge_crosses(poly_x[k], poly_y[k], poly_x[n], poly_y[n], c.x, c.y))
            crossings++;
        end
        r.in_poly = crossings[0];
      end
    endcase
    r.count = CntBits'(poly_len);
    return r;
  endfunction

  // Pick a point: mostly near a coarse grid, sometimes fully random
  function automatic coord_t pick_coord();
    int j;
    if ($urandom_range(99) < 15) return coord_t'($urandom);
    j = int'($urandom_range(40)) - 20;
    return coord_t'((int'($urandom_range(12)) - 6) * Grid + j);
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_en) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(150, 10);
  endfunction

  task automatic push_cmd(opcode_t op, coord_t x, coord_t y);
    poly_cmd_t c;
    c.op = op;
    c.x  = x;
    c.y  = y;
    cmd_queue.insert(cmd_queue.size(), c);
  endtask

  // Queue a phase of random commands, add_pct percent of them adds
  task automatic push_random(int num, int add_pct);
    int      r;
    opcode_t op;
    for (int i = 0; i < num; i++) begin
      r = $urandom_range(99);
      if (r < add_pct) op = OP_ADD;
      else begin
        case ($urandom_range(2))
          0:       op = OP_REMOVE;
          1:       op = OP_MOVE;
          default: op = OP_INSIDE;
        endcase
      end
      push_cmd(op, pick_coord(), pick_coord());
    end
  endtask

  // Hold until the block has drained, then let it settle
  task automatic drain();
    while (cmd_queue.size() > 0 || resp_queue.size() > 0 || in_ch.valid)
      @(negedge clk);
    repeat (Settle) @(negedge clk);
  endtask

  task automatic write_thr(logic [ThrBits-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Driver: present the next queued command once the previous one is taken
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_taken)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
        in_ch.data  <= cmd_queue.pop_front();
        in_ch.valid <= 1'b1;
        in_gap = pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, with two long hold-offs
  always @(negedge clk) begin
    if (cyc % 500 == 0) idle_en = ($urandom_range(3) != 0);
    if (cyc == 3000 || cyc == 40000) out_hold = 400;
    if (out_hold > 0) begin
      out_hold--;
      out_ch.ready <= 1'b0;
    end else if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (pick_gap() > 0) out_hold = pick_gap();
    end
  end

  // Monitor: predict on accepted commands, check accepted responses
  always @(posedge clk) begin
    poly_resp_t exp_r;
    cyc++;
    in_taken <= in_ch.valid && in_ch.ready;
    if (rst_n && cfg_ch.valid && cfg_ch.ready) snap_thr = cfg_ch.data;
    if (rst_n && in_ch.valid && in_ch.ready)
      resp_queue.insert(resp_queue.size(), apply_cmd(in_ch.data));
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (resp_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response %p", out_ch.data);
      end else begin
        exp_r = resp_queue.pop_front();
        if (exp_r !== out_ch.data) begin
          errors++;
          if (errors <= 10)
            $display("response mismatch: expected %p, got %p", exp_r, out_ch.data);
        end
      end
    end
    if (cyc > CycLimit) begin
      $display("polygon_vertex_table_with_inside_test: mismatch");
      $finish;
    end
  end

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    rst_n        = 1'b0;
    poly_len     = 0;
    snap_thr     = ThrReset;
    errors       = 0;
    cyc          = 0;
    in_gap       = 0;
    out_hold     = 0;
    idle_en      = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty table, field extremes, exact hits, misses, origin
    push_cmd(OP_INSIDE, 24'sd100, 24'sd100);
    push_cmd(OP_REMOVE, 24'sd0, 24'sd0);
    push_cmd(OP_MOVE, 24'sd0, 24'sd0);
    push_cmd(OP_ADD, -24'sd1024, -24'sd1024);
    push_cmd(OP_ADD, 24'sd1024, -24'sd1024);
    push_cmd(OP_ADD, 24'sd1024, 24'sd1024);
    push_cmd(OP_ADD, -24'sd1024, 24'sd1024);
    push_cmd(OP_INSIDE, 24'sd10, 24'sd20);
    push_cmd(OP_INSIDE, 24'sd4000, 24'sd300);
    push_cmd(OP_INSIDE, 24'sd0, 24'sd0);
    push_cmd(OP_INSIDE, 24'sd1024, 24'sd0);
    push_cmd(OP_INSIDE, 24'sd2048, 24'sd2048);
    push_cmd(OP_ADD, 24'sh7FFFFF, 24'sh7FFFFF);
    push_cmd(OP_ADD, -24'sh800000, -24'sh800000);
    push_cmd(OP_INSIDE, 24'sh7FFFFF, -24'sh800000);
    push_cmd(OP_MOVE, 24'sd1024, 24'sd1028);
    push_cmd(OP_REMOVE, 24'sd500, 24'sd500);
    push_cmd(OP_REMOVE, -24'sh800000, -24'sh800000);
    push_cmd(OP_MOVE, 24'sh7FFFFF, 24'sh7FFFFF);
    push_cmd(OP_REMOVE, -24'sd1024, -24'sd1024);
    push_cmd(OP_INSIDE, -24'sh800000, 24'sh7FFFFF);
    drain();

    // Zero threshold: nothing ever hits
    write_thr('0);
    push_random(80, 40);
    drain();

    // Maximum threshold: nearly everything hits
    write_thr(ThrMax);
    push_random(120, 50);
    drain();

    // Mid thresholds: fill the table past full, then thin it out
    write_thr(ThrBits'(64'd1 << 20));
    push_random(220, 75);
    push_random(200, 25);
    drain();

    write_thr(ThrBits'(64'd1 << 24));
    push_random(200, 45);
    drain();

    write_thr(ThrBits'({$urandom, $urandom}));
    push_random(100, 50);
    drain();

    write_thr(ThrReset);
    push_random(120, 50);
    drain();

    if (resp_queue.size() != 0) errors++;
    if (errors == 0) begin
      $display("polygon_vertex_table_with_inside_test: match");
    end else begin
      $display("polygon_vertex_table_with_inside_test: mismatch");
    end
    $finish;
  end

endmodule
